// ----- hdl/dxt1ba_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// dxt1ba_pkg
// Shared widths, block mode codes and index tables for the DXT1 block
// assembler.
// ---------------------------------------------------------------------------
package dxt1ba_pkg;

    localparam int FORMAT_W   = 24;
    localparam int CHANNEL_W  = 8;
    localparam int SELECTOR_W = 16;
    localparam int COLOR565_W = 16;
    localparam int INDEX_W    = 32;

    // format word bits 6:4 equal to this mark move the mode field from bits 3:0 to bits 15:12
    localparam logic [2:0] ALT_MODE_MARK = 3'b111;

    // index bit patterns of the constant modes
    localparam logic [INDEX_W-1:0] PATTERN_ZERO  = 32'h0000_0000;
    localparam logic [INDEX_W-1:0] PATTERN_TWO   = 32'hAAAA_AAAA;
    localparam logic [INDEX_W-1:0] PATTERN_THREE = 32'hFFFF_FFFF;
    localparam logic [INDEX_W-1:0] PATTERN_ONE   = 32'h5555_5555;

    // xor applied to index bytes when the endpoints are swapped
    localparam logic [7:0] SWAP_FLIP = 8'h55;

    typedef enum logic [3:0] {
        MODE_CONST_0  = 4'd0,
        MODE_CONST_2  = 4'd1,
        MODE_CONST_3  = 4'd2,
        MODE_CONST_1  = 4'd3,
        MODE_BLOCK_1  = 4'd4,
        MODE_BLOCK_2  = 4'd5,
        MODE_BLOCK_3  = 4'd6,
        MODE_BLOCK_4  = 4'd7,
        MODE_HALF_1   = 4'd8,
        MODE_HALF_2   = 4'd9,
        MODE_HALF_3   = 4'd10,
        MODE_HALF_4   = 4'd11,
        MODE_NIBBLE   = 4'd12,
        MODE_PIXEL_2  = 4'd13,
        MODE_PIXEL_3  = 4'd14,
        MODE_PIXEL_4  = 4'd15
    } mode_t;

    // input request as held in the input register
    typedef struct packed {
        logic [FORMAT_W-1:0]   format_word;
        logic [CHANNEL_W-1:0]  first_red;
        logic [CHANNEL_W-1:0]  first_green;
        logic [CHANNEL_W-1:0]  first_blue;
        logic [CHANNEL_W-1:0]  second_red;
        logic [CHANNEL_W-1:0]  second_green;
        logic [CHANNEL_W-1:0]  second_blue;
        logic [SELECTOR_W-1:0] selector_zero;
        logic [SELECTOR_W-1:0] selector_one;
        logic [SELECTOR_W-1:0] selector_two;
        logic [SELECTOR_W-1:0] selector_three;
    } block_req_t;

    // selector levels 0,1,2,3 map to dxt1 indices 0,2,3,1 (a two-bit field of a selector)
    function automatic logic [1:0] level_to_index(input logic [1:0] level);
        logic [1:0] idx;
        case (level)
            2'd0:    idx = 2'd0;
            2'd1:    idx = 2'd2;
            2'd2:    idx = 2'd3;
            default: idx = 2'd1;
        endcase
        return idx;
    endfunction

    // repeat one 2-bit index over all four pixels of a byte
    function automatic logic [7:0] splat(input logic [1:0] idx);
        return {idx, idx, idx, idx};
    endfunction

    // nibble table: bit 3 gives pixel 0, bit 0 gives pixel 3, one bit per pixel
    function automatic logic [7:0] nibble_row(input logic [3:0] nib);
        return {1'b0, nib[0], 1'b0, nib[1], 1'b0, nib[2], 1'b0, nib[3]};
    endfunction

    // convert an rgb888 color to rgb565
    function automatic logic [COLOR565_W-1:0] to565(
        input logic [CHANNEL_W-1:0] r,
        input logic [CHANNEL_W-1:0] g,
        input logic [CHANNEL_W-1:0] b
    );
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

`default_nettype wire

// ----- hdl/dxt1ba_if.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// dxt1ba interfaces
// Valid/ready channels for block requests and packed block results.
// ---------------------------------------------------------------------------
interface dxt1ba_req_if;
    logic                                valid;
    logic                                ready;
    logic [dxt1ba_pkg::FORMAT_W-1:0]     format_word;
    logic [dxt1ba_pkg::CHANNEL_W-1:0]    first_red;
    logic [dxt1ba_pkg::CHANNEL_W-1:0]    first_green;
    logic [dxt1ba_pkg::CHANNEL_W-1:0]    first_blue;
    logic [dxt1ba_pkg::CHANNEL_W-1:0]    second_red;
    logic [dxt1ba_pkg::CHANNEL_W-1:0]    second_green;
    logic [dxt1ba_pkg::CHANNEL_W-1:0]    second_blue;
    logic [dxt1ba_pkg::SELECTOR_W-1:0]   selector_zero;
    logic [dxt1ba_pkg::SELECTOR_W-1:0]   selector_one;
    logic [dxt1ba_pkg::SELECTOR_W-1:0]   selector_two;
    logic [dxt1ba_pkg::SELECTOR_W-1:0]   selector_three;

    modport source (
        output valid, format_word, first_red, first_green, first_blue,
               second_red, second_green, second_blue,
               selector_zero, selector_one, selector_two, selector_three,
        input  ready
    );
    modport sink (
        input  valid, format_word, first_red, first_green, first_blue,
               second_red, second_green, second_blue,
               selector_zero, selector_one, selector_two, selector_three,
        output ready
    );
endinterface

interface dxt1ba_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [dxt1ba_pkg::COLOR565_W-1:0]   endpoint_high;
    logic [dxt1ba_pkg::COLOR565_W-1:0]   endpoint_low;
    logic [dxt1ba_pkg::INDEX_W-1:0]      index_bytes;

    modport source (
        output valid, endpoint_high, endpoint_low, index_bytes,
        input  ready
    );
    modport sink (
        input  valid, endpoint_high, endpoint_low, index_bytes,
        output ready
    );
endinterface

`default_nettype wire

// ----- hdl/dxt1_block_assembler_top.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// dxt1_block_assembler_top
// Packs a format word, two rgb888 endpoints and four selectors into the
// endpoint and index words of one dxt1 color block.
// ---------------------------------------------------------------------------
// Takes one request per cycle and returns one packed block per request, in
// order. The request is captured in an input register, the 565 packing,
// endpoint ordering and index expansion run in one level of logic, and the
// block is held in a result register until taken. Throughput is one block per
// clock as long as the result side keeps taking them; a stalled result holds
// the pipeline and drops ready once the input register is full.
module dxt1_block_assembler_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    dxt1ba_req_if.sink       request,
    dxt1ba_rsp_if.source     result
);

    // pipeline control
    logic                          in_valid_reg;
    logic                          out_valid_reg;
    logic                          out_advance;
    logic                          in_advance;

    dxt1ba_pkg::block_req_t        req_reg;

    logic [dxt1ba_pkg::COLOR565_W-1:0] high_reg, high_next;
    logic [dxt1ba_pkg::COLOR565_W-1:0] low_reg, low_next;
    logic [dxt1ba_pkg::INDEX_W-1:0]    index_reg, index_next;

    assign out_advance   = !out_valid_reg || result.ready;
    assign in_advance    = !in_valid_reg || out_advance;
    assign request.ready = in_advance;

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_advance)
                in_valid_reg <= request.valid;
            if (out_advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (in_advance && request.valid)
        begin
            req_reg.format_word    <= request.format_word;
            req_reg.first_red      <= request.first_red;
            req_reg.first_green    <= request.first_green;
            req_reg.first_blue     <= request.first_blue;
            req_reg.second_red     <= request.second_red;
            req_reg.second_green   <= request.second_green;
            req_reg.second_blue    <= request.second_blue;
            req_reg.selector_zero  <= request.selector_zero;
            req_reg.selector_one   <= request.selector_one;
            req_reg.selector_two   <= request.selector_two;
            req_reg.selector_three <= request.selector_three;
        end
    end

    // block assembly
    always_comb
    begin
        logic [dxt1ba_pkg::COLOR565_W-1:0] color_a;
        logic [dxt1ba_pkg::COLOR565_W-1:0] color_b;
        logic [7:0]                        flip;
        dxt1ba_pkg::mode_t                 mode;
        logic [dxt1ba_pkg::SELECTOR_W-1:0] sel [4];
        logic [1:0]                        pix [4];
        logic [7:0]                        row [4];
        logic [7:0]                        whole;
        logic [7:0]                        half_a;
        logic [7:0]                        half_b;

        color_a = dxt1ba_pkg::to565(req_reg.first_red, req_reg.first_green,
                                    req_reg.first_blue);
        color_b = dxt1ba_pkg::to565(req_reg.second_red, req_reg.second_green,
                                    req_reg.second_blue);

        // larger endpoint first, flip indices on swap
        if (color_a < color_b)
        begin
            high_next = color_b;
            low_next  = color_a;
            flip      = dxt1ba_pkg::SWAP_FLIP;
        end
        else
        begin
            high_next = color_a;
            low_next  = color_b;
            flip      = '0;
        end

        // mode field select
        if (req_reg.format_word[6:4] == dxt1ba_pkg::ALT_MODE_MARK)
            mode = dxt1ba_pkg::mode_t'(req_reg.format_word[15:12]);
        else
            mode = dxt1ba_pkg::mode_t'(req_reg.format_word[3:0]);

        sel[0] = req_reg.selector_zero;
        sel[1] = req_reg.selector_one;
        sel[2] = req_reg.selector_two;
        sel[3] = req_reg.selector_three;

        // per-selector pixel index for the whole-block and half modes
        for (int k = 0; k < 4; k++)
        begin
            case (mode)
                dxt1ba_pkg::MODE_BLOCK_1, dxt1ba_pkg::MODE_HALF_1:
                    pix[k] = {1'b0, sel[k][0]};
                dxt1ba_pkg::MODE_BLOCK_2, dxt1ba_pkg::MODE_HALF_2:
                    pix[k] = dxt1ba_pkg::level_to_index(sel[k][1:0]);
                dxt1ba_pkg::MODE_BLOCK_3, dxt1ba_pkg::MODE_HALF_3:
                    pix[k] = dxt1ba_pkg::level_to_index(sel[k][2:1]);
                default:
                    pix[k] = dxt1ba_pkg::level_to_index(sel[k][3:2]);
            endcase
        end

        // per-row bytes for the per-pixel modes, field of pixel 0 on top
        for (int k = 0; k < 4; k++)
        begin
            for (int p = 0; p < 4; p++)
            begin
                case (mode)
                    dxt1ba_pkg::MODE_PIXEL_2:
                        row[k][2*p +: 2] =
                            dxt1ba_pkg::level_to_index(sel[k][2*(3-p) +: 2]);
                    dxt1ba_pkg::MODE_PIXEL_3:
                        row[k][2*p +: 2] =
                            dxt1ba_pkg::level_to_index(sel[k][3*(3-p)+1 +: 2]);
                    default:
                        row[k][2*p +: 2] =
                            dxt1ba_pkg::level_to_index(sel[k][4*(3-p)+2 +: 2]);
                endcase
            end
        end

        whole  = dxt1ba_pkg::splat(pix[0]) ^ flip;
        half_a = {pix[1], pix[1], pix[0], pix[0]} ^ flip;
        half_b = {pix[3], pix[3], pix[2], pix[2]} ^ flip;

        // index word by mode
        unique case (mode)
            dxt1ba_pkg::MODE_CONST_0: index_next = dxt1ba_pkg::PATTERN_ZERO;
            dxt1ba_pkg::MODE_CONST_2: index_next = dxt1ba_pkg::PATTERN_TWO;
            dxt1ba_pkg::MODE_CONST_3: index_next = dxt1ba_pkg::PATTERN_THREE;
            dxt1ba_pkg::MODE_CONST_1: index_next = dxt1ba_pkg::PATTERN_ONE;
            dxt1ba_pkg::MODE_BLOCK_1, dxt1ba_pkg::MODE_BLOCK_2,
            dxt1ba_pkg::MODE_BLOCK_3, dxt1ba_pkg::MODE_BLOCK_4:
                index_next = {whole, whole, whole, whole};
            dxt1ba_pkg::MODE_HALF_1, dxt1ba_pkg::MODE_HALF_2,
            dxt1ba_pkg::MODE_HALF_3, dxt1ba_pkg::MODE_HALF_4:
                index_next = {half_b, half_b, half_a, half_a};
            dxt1ba_pkg::MODE_NIBBLE:
                index_next = {dxt1ba_pkg::nibble_row(sel[1][3:0]) ^ flip,
                              dxt1ba_pkg::nibble_row(sel[1][7:4]) ^ flip,
                              dxt1ba_pkg::nibble_row(sel[0][3:0]) ^ flip,
                              dxt1ba_pkg::nibble_row(sel[0][7:4]) ^ flip};
            default:
                index_next = {row[3] ^ flip, row[2] ^ flip,
                              row[1] ^ flip, row[0] ^ flip};
        endcase
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (out_advance && in_valid_reg)
        begin
            high_reg  <= high_next;
            low_reg   <= low_next;
            index_reg <= index_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.endpoint_high = high_reg;
    assign result.endpoint_low  = low_reg;
    assign result.index_bytes   = index_reg;

endmodule

`default_nettype wire
